@@ rtl/wsp_pkg.sv @@
// Package for the world-to-screen projection unit: widths, opcodes, queue entry type.
// Used by every module of the unit; no dependencies.
package wsp_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W = 32;
  localparam int DIM_W = 14;
  localparam logic [DIM_W-1:0] WIDTH_RST = 14'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd1080;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  typedef enum logic {
    REG_WIDTH = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // transform item as it travels from the front end to the back end
  typedef struct packed {
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic signed [DATA_W-1:0] cw;
  } clip_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [80:0] v);
    logic signed [80:0] mx;
    logic signed [80:0] mn;
    begin
      mx = 81'sd2147483647;
      mn = -81'sd2147483648;
      if (v > mx) sat32 = 32'sh7fffffff;
      else if (v < mn) sat32 = 32'sh80000000;
      else sat32 = v[DATA_W-1:0];
    end
  endfunction
endpackage

@@ rtl/wsp_front.sv @@
// Front end: holds the matrix, applies loads, and computes clip x/y/w for transforms.
// Depends on wsp_pkg. Two register stages: products, then summed and saturated rows.
module wsp_front import wsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_opcode,
  input  logic [3:0] in_coeff_index,
  input  logic signed [DATA_W-1:0] in_coeff_value,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_point_z,
  input  logic q_room,
  output logic q_push,
  output clip_t q_data
);
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'sd1 <<< FRAC_BITS);

  logic signed [DATA_W-1:0] mat_r [16];
  logic signed [63:0] prod_r [12];
  logic p1_valid_r, p2_valid_r;
  clip_t clip_r;
  logic acc;
  logic adv;

  // pipeline advances only when queue has room; a slot is reserved per stage
  assign adv = q_room;
  assign in_stall = !adv;
  assign acc = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++)
        mat_r[i] <= (i % 5 == 0) ? ONE : '0;
    end else if (acc && op_t'(in_opcode) == OP_LOAD) begin
      mat_r[in_coeff_index] <= in_coeff_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= acc && op_t'(in_opcode) == OP_XFORM;
      p2_valid_r <= p1_valid_r;
    end
  end

  // rows 0, 1, 3; fourth column multiplies by one
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r*4+0] <= 64'(mat_r[(r == 2 ? 3 : r)*4+0]) * 64'(in_point_x);
        prod_r[r*4+1] <= 64'(mat_r[(r == 2 ? 3 : r)*4+1]) * 64'(in_point_y);
        prod_r[r*4+2] <= 64'(mat_r[(r == 2 ? 3 : r)*4+2]) * 64'(in_point_z);
        prod_r[r*4+3] <= 64'(mat_r[(r == 2 ? 3 : r)*4+3]) <<< FRAC_BITS;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] row_sum(input int r);
    logic signed [66:0] s;
    begin
      s = 67'(prod_r[r*4]) + 67'(prod_r[r*4+1]) + 67'(prod_r[r*4+2]) + 67'(prod_r[r*4+3]);
      row_sum = sat32(81'(s >>> FRAC_BITS));
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r.cx <= row_sum(0);
      clip_r.cy <= row_sum(1);
      clip_r.cw <= row_sum(2);
    end
  end

  assign q_push = p2_valid_r && adv;
  assign q_data = clip_r;
endmodule

@@ rtl/wsp_queue.sv @@
// Short FIFO between the front end and the back end.
// Depends on wsp_pkg. Room is reported while enough slots remain for in-flight items.
module wsp_queue import wsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  clip_t push_data,
  input  logic pop,
  output logic nonempty,
  output clip_t head,
  output logic room
);
  localparam int DEPTH = 8;
  localparam int AW = 3;
  clip_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign nonempty = cnt_r != '0;
  assign head = mem_r[rp_r];
  // two items may still be in the front pipeline
  assign room = cnt_r <= (AW+1)'(DEPTH - 3);

  assert property (@(posedge clk) disable iff (!rst_n) !(push && cnt_r == (AW+1)'(DEPTH)))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
    else $error("queue underflow");
endmodule

@@ rtl/wsp_divider.sv @@
// Back end: pipelined restoring divider for ndc = clip*one/w, then viewport mapping.
// Needs wsp_pkg. One x and y quotient bit per stage; one item per cycle unless stalled.
module wsp_back import wsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_nonempty,
  input  clip_t q_head,
  output logic q_pop,
  input  logic [DIM_W-1:0] width,
  input  logic [DIM_W-1:0] height,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [DATA_W-1:0] out_screen_x,
  output logic signed [DATA_W-1:0] out_screen_y,
  output logic out_behind_camera
);
  localparam int NW = DATA_W + FRAC_BITS;    // dividend magnitude width
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] BEHIND_V =
    sat32(-81'sd10000 <<< FRAC_BITS);

  typedef struct packed {
    logic vld;
    logic behind;
    logic nx_neg;
    logic ny_neg;
    logic [NW-1:0] qx;
    logic [NW-1:0] qy;
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
    logic [DATA_W-2:0] d;
  } dstage_t;

  dstage_t s_r [NW+1];
  logic signed [DATA_W-1:0] nx_r, ny_r;
  logic m_vld_r, m_beh_r;
  logic signed [DATA_W-1:0] sx_r, sy_r;
  logic beh_r, ov_r;
  logic adv;

  // one restoring step: shift in the next dividend bit, subtract, keep if non-negative
  function automatic dstage_t div_step(input dstage_t s);
    dstage_t n;
    logic [NW:0] tx, ty;
    begin
      n = s;
      tx = {s.rx, s.qx[NW-1]} - (NW+1)'(s.d);
      ty = {s.ry, s.qy[NW-1]} - (NW+1)'(s.d);
      n.qx = {s.qx[NW-2:0], !tx[NW]};
      n.qy = {s.qy[NW-2:0], !ty[NW]};
      n.rx = tx[NW] ? {s.rx[NW-2:0], s.qx[NW-1]} : tx[NW-1:0];
      n.ry = ty[NW] ? {s.ry[NW-2:0], s.qy[NW-1]} : ty[NW-1:0];
      div_step = n;
    end
  endfunction

  // whole pipeline stalls together; output register is last stage
  assign adv = !(ov_r && out_stall);
  assign q_pop = q_nonempty && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NW; i++)
        s_r[i].vld <= 1'b0;
    end else if (adv) begin
      s_r[0].vld <= q_pop;
      s_r[0].behind <= q_head.cw <= 0;
      s_r[0].nx_neg <= q_head.cx < 0;
      s_r[0].ny_neg <= q_head.cy < 0;
      s_r[0].qx <= NW'(q_head.cx < 0 ? -33'(q_head.cx) : 33'(q_head.cx)) << FRAC_BITS;
      s_r[0].qy <= NW'(q_head.cy < 0 ? -33'(q_head.cy) : 33'(q_head.cy)) << FRAC_BITS;
      s_r[0].rx <= '0;
      s_r[0].ry <= '0;
      s_r[0].d <= q_head.cw[DATA_W-2:0];
      for (int i = 0; i < NW; i++)
        s_r[i+1] <= div_step(s_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= sat32(s_r[NW].nx_neg ? -81'(s_r[NW].qx) : 81'(s_r[NW].qx));
      ny_r <= sat32(s_r[NW].ny_neg ? -81'(s_r[NW].qy) : 81'(s_r[NW].qy));
      sx_r <= sat32(((81'(nx_r) + 81'(ONE)) * 81'($signed({1'b0, width}))) >>> 1);
      sy_r <= sat32(((81'(ONE) - 81'(ny_r)) * 81'($signed({1'b0, height}))) >>> 1);
      beh_r <= m_beh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= s_r[NW].vld;
      ov_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) m_beh_r <= s_r[NW].behind;
  end

  assign out_valid = ov_r;
  assign out_screen_x = beh_r ? BEHIND_V : sx_r;
  assign out_screen_y = beh_r ? BEHIND_V : sy_r;
  assign out_behind_camera = beh_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_screen_x)))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_behind_camera) |-> (out_screen_x == out_screen_y))
    else $error("behind result mismatch");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_nonempty)
    else $error("pop without item");
endmodule

@@ rtl/world_to_screen_projection.sv @@
// World-to-screen projection unit, top level. Depends on wsp_pkg, wsp_front, wsp_queue, wsp_back.
// Throughput: one item per cycle unless out_stall or queue back-pressure holds the flow.
// A transform passes front products and rows, the queue, back input, divider stages (one
// quotient bit each), ndc and screen registers. Input stalls once the queue holds six items.
// Reset (synchronous, rst_n low): matrix to identity, viewport to 1920x1080, pipeline empty.
module world_to_screen_projection import wsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_opcode,
  input  logic [3:0] in_coeff_index,
  input  logic signed [DATA_W-1:0] in_coeff_value,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_point_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [DATA_W-1:0] out_screen_x,
  output logic signed [DATA_W-1:0] out_screen_y,
  output logic out_behind_camera,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);
  logic [DIM_W-1:0] width_r, height_r;
  logic q_room, q_push, q_pop, q_ne;
  clip_t q_in, q_head;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wsp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_coeff_index, .in_coeff_value,
    .in_point_x, .in_point_y, .in_point_z, .q_room, .q_push, .q_data(q_in)
  );

  wsp_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop), .nonempty(q_ne),
    .head(q_head), .room(q_room)
  );

  wsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_nonempty(q_ne), .q_head, .q_pop, .width(width_r), .height(height_r),
    .out_valid, .out_stall, .out_screen_x, .out_screen_y, .out_behind_camera
  );
endmodule
